// ----- design/itp_pkg.sv -----
// Package for the infix to postfix converter: operator codes, output select codes,
// and the command and status groups exchanged between the controller and the datapath.
// No dependencies.
package itp_pkg;

  // Default depth of the operator stack
  localparam int unsigned STACK_DEPTH_DEF = 16;

  // Width of one stored operator code
  localparam int unsigned OP_W = 2;

  // Operator characters
  localparam logic [7:0] CHAR_ADD = 8'h2B;
  localparam logic [7:0] CHAR_SUB = 8'h2D;
  localparam logic [7:0] CHAR_MUL = 8'h2A;
  localparam logic [7:0] CHAR_DIV = 8'h2F;

  // Stored operator codes; the upper bit marks the higher precedence
  localparam logic [OP_W-1:0] OP_ADD = 2'd0;
  localparam logic [OP_W-1:0] OP_SUB = 2'd1;
  localparam logic [OP_W-1:0] OP_MUL = 2'd2;
  localparam logic [OP_W-1:0] OP_DIV = 2'd3;

  // Source of the next result loaded into the output register
  typedef enum logic [1:0] {
    SEL_OPERAND = 2'd0,
    SEL_POP     = 2'd1,
    SEL_PEND    = 2'd2,
    SEL_END     = 2'd3
  } out_sel_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic     load_item;
    logic     out_load;
    out_sel_e out_sel;
    logic     out_last;
    logic     rd_en;
    logic     cnt_dec;
    logic     push;
    logic     end_clear;
    logic     pend_set;
    logic     pend_clr;
  } ctl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic is_end;
    logic is_op;
    logic cnt_zero;
    logic qualifies;
    logic pend_valid;
    logic out_free;
  } ctl_sts_t;

  // Map an operator character to its code
  function automatic logic [OP_W-1:0] op_code_of(input logic [7:0] sym);
    logic [OP_W-1:0] code;
    code = OP_ADD;
    case (sym)
      CHAR_ADD: code = OP_ADD;
      CHAR_SUB: code = OP_SUB;
      CHAR_MUL: code = OP_MUL;
      CHAR_DIV: code = OP_DIV;
      default:  code = OP_ADD;
    endcase
    return code;
  endfunction

  // Map an operator code back to its character
  function automatic logic [7:0] op_char_of(input logic [OP_W-1:0] code);
    logic [7:0] ch;
    ch = CHAR_ADD;
    case (code)
      OP_ADD:  ch = CHAR_ADD;
      OP_SUB:  ch = CHAR_SUB;
      OP_MUL:  ch = CHAR_MUL;
      OP_DIV:  ch = CHAR_DIV;
      default: ch = CHAR_ADD;
    endcase
    return ch;
  endfunction

endpackage

// ----- design/itp_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module itp_ram #(
  parameter int unsigned Width = 2,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; hold data between reads
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/itp_ctrl.sv -----
// Controller for the infix to postfix converter: sequences operand pass-through,
// stack pops, pushes and the end flush. Uses itp_pkg.
module itp_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  itp_pkg::ctl_sts_t sts_i,
  output itp_pkg::ctl_cmd_t cmd_o
);
  import itp_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_LOOK   = 4'b0010,
    S_CMP    = 4'b0100,
    S_FINISH = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // Take a request only while idle
  assign in_stall_o = (state_q != S_IDLE);

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.out_sel = SEL_OPERAND;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = S_LOOK;
        end
      end
      S_LOOK: begin
        if (!sts_i.is_end && !sts_i.is_op) begin
          // Pass the operand straight out
          if (sts_i.out_free) begin
            cmd_o.out_load = 1'b1;
            cmd_o.out_sel  = SEL_OPERAND;
            cmd_o.out_last = 1'b1;
            state_d        = S_IDLE;
          end
        end else if (sts_i.cnt_zero) begin
          state_d = S_FINISH;
        end else begin
          cmd_o.rd_en = 1'b1;
          state_d     = S_CMP;
        end
      end
      S_CMP: begin
        if (sts_i.is_end) begin
          // Flush: every entry is popped
          if (sts_i.out_free) begin
            cmd_o.out_load = 1'b1;
            cmd_o.out_sel  = SEL_POP;
            cmd_o.cnt_dec  = 1'b1;
            state_d        = S_LOOK;
          end
        end else if (sts_i.qualifies) begin
          // Pop into the pending slot, releasing the previous pop as not last
          if (!sts_i.pend_valid) begin
            cmd_o.pend_set = 1'b1;
            cmd_o.cnt_dec  = 1'b1;
            state_d        = S_LOOK;
          end else if (sts_i.out_free) begin
            cmd_o.out_load = 1'b1;
            cmd_o.out_sel  = SEL_PEND;
            cmd_o.pend_set = 1'b1;
            cmd_o.cnt_dec  = 1'b1;
            state_d        = S_LOOK;
          end
        end else begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (sts_i.is_end) begin
          // Close the expression with the end marker
          if (sts_i.out_free) begin
            cmd_o.out_load  = 1'b1;
            cmd_o.out_sel   = SEL_END;
            cmd_o.out_last  = 1'b1;
            cmd_o.end_clear = 1'b1;
            state_d         = S_IDLE;
          end
        end else if (sts_i.pend_valid) begin
          // Release the final pop as last and push the operator
          if (sts_i.out_free) begin
            cmd_o.out_load = 1'b1;
            cmd_o.out_sel  = SEL_PEND;
            cmd_o.out_last = 1'b1;
            cmd_o.pend_clr = 1'b1;
            cmd_o.push     = 1'b1;
            state_d        = S_IDLE;
          end
        end else begin
          cmd_o.push = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- design/itp_datapath.sv -----
// Datapath for the infix to postfix converter: request register, operator stack,
// stack count, overflow flag, pending pop and output register. Uses itp_pkg, itp_ram.
module itp_datapath #(
  parameter int unsigned StackDepth = itp_pkg::STACK_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [7:0]        symbol_i,
  input  logic              end_of_input_i,
  input  logic              out_stall_i,
  output logic              out_valid_o,
  output logic [7:0]        out_symbol_o,
  output logic              end_marker_o,
  output logic              overflow_o,
  output logic              last_o,
  input  itp_pkg::ctl_cmd_t cmd_i,
  output itp_pkg::ctl_sts_t sts_o
);
  import itp_pkg::*;

  localparam int unsigned AddrW = (StackDepth > 1) ? $clog2(StackDepth) : 1;
  localparam int unsigned CntW  = $clog2(StackDepth + 1);

  logic [7:0]      sym_q;
  logic            end_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            ovf_q, ovf_d;
  logic [OP_W-1:0] pend_q;
  logic            pend_valid_q;
  logic [OP_W-1:0] rdata;
  logic [OP_W-1:0] item_code;
  logic            item_is_op;
  logic            stack_full;
  logic [CntW-1:0] rd_cnt;
  logic            out_valid_q;
  logic [7:0]      out_sym_q;
  logic            out_end_q;
  logic            out_ovf_q;
  logic            out_last_q;
  logic            ram_we;

  // Decode the held request
  always_comb begin
    item_is_op = sym_q inside {CHAR_ADD, CHAR_SUB, CHAR_MUL, CHAR_DIV};
  end
  assign item_code  = op_code_of(sym_q);
  assign stack_full = (cnt_q == CntW'(StackDepth));
  assign rd_cnt     = cnt_q - CntW'(1);
  assign ram_we     = cmd_i.push && !stack_full;

  // Hold the accepted request
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      sym_q <= symbol_i;
      end_q <= end_of_input_i;
    end
  end

  // Operator stack storage
  itp_ram #(
    .Width (OP_W),
    .Depth (StackDepth)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cnt_q[AddrW-1:0]),
    .wdata_i (item_code),
    .re_i    (cmd_i.rd_en),
    .raddr_i (rd_cnt[AddrW-1:0]),
    .rdata_o (rdata)
  );

  // Advance the stack count and the sticky overflow flag
  always_comb begin
    cnt_d = cnt_q;
    ovf_d = ovf_q;
    if (cmd_i.end_clear) begin
      cnt_d = '0;
      ovf_d = 1'b0;
    end else if (cmd_i.cnt_dec) begin
      cnt_d = rd_cnt;
    end else if (cmd_i.push) begin
      if (stack_full) begin
        ovf_d = 1'b1;
      end else begin
        cnt_d = cnt_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ovf_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      ovf_q <= ovf_d;
    end
  end

  // Pending pop, released once it is known whether it is the last one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
    end else if (cmd_i.pend_set) begin
      pend_valid_q <= 1'b1;
    end else if (cmd_i.pend_clr) begin
      pend_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pend_set) begin
      pend_q <= rdata;
    end
  end

  // Output register: load a result, drop valid once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_last_q <= cmd_i.out_last;
      case (cmd_i.out_sel)
        SEL_OPERAND: begin
          out_sym_q <= sym_q;
          out_end_q <= 1'b0;
          out_ovf_q <= 1'b0;
        end
        SEL_POP: begin
          out_sym_q <= op_char_of(rdata);
          out_end_q <= 1'b0;
          out_ovf_q <= 1'b0;
        end
        SEL_PEND: begin
          out_sym_q <= op_char_of(pend_q);
          out_end_q <= 1'b0;
          out_ovf_q <= 1'b0;
        end
        SEL_END: begin
          out_sym_q <= 8'd0;
          out_end_q <= 1'b1;
          out_ovf_q <= ovf_q;
        end
        default: begin
          out_sym_q <= 8'd0;
          out_end_q <= 1'b0;
          out_ovf_q <= 1'b0;
        end
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_symbol_o = out_sym_q;
  assign end_marker_o = out_end_q;
  assign overflow_o   = out_ovf_q;
  assign last_o       = out_last_q;

  // Status towards the controller
  always_comb begin
    sts_o.is_end     = end_q;
    sts_o.is_op      = item_is_op;
    sts_o.cnt_zero   = (cnt_q == '0);
    sts_o.qualifies  = rdata[1] || !item_code[1];
    sts_o.pend_valid = pend_valid_q;
    sts_o.out_free   = !out_valid_q || !out_stall_i;
  end

endmodule

// ----- design/infix_to_postfix_converter.sv -----
// Top level of the infix to postfix converter: joins the controller and the datapath.
// Uses itp_pkg, itp_ctrl, itp_datapath.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o, symbol_i, end_of_input_i) takes one byte
//   per request. Operators + - * / are stacked; any other byte is an operand and
//   passes straight out. A request with end_of_input_i set flushes the stack and
//   closes with an end marker whose overflow_o reports a dropped push.
//   Output channel (out_valid_o / out_stall_i) carries out_symbol_o, end_marker_o,
//   overflow_o and last_o; last_o marks the final result of each request.
// Sequence:
//   An operand goes to the output register from S_LOOK. An operator passes S_LOOK and
//   S_CMP once per popped entry and once more when an entry is left on the stack, then
//   is pushed in S_FINISH; an end request pops every stacked entry, then sends the
//   marker from S_FINISH. Each pop costs one stack read and one compare.
// Reset: the stack is empty and the overflow flag is clear; stack contents
//   are not cleared and need no clearing pass.
// Stall: the output register holds its result while out_stall_i is high; the
//   controller waits and in_stall_o stays high until the request is done.
module infix_to_postfix_converter #(
  parameter int unsigned StackDepth = itp_pkg::STACK_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] symbol_i,
  input  logic       end_of_input_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_symbol_o,
  output logic       end_marker_o,
  output logic       overflow_o,
  output logic       last_o
);
  import itp_pkg::*;

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  // Sequence each request
  itp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Stack, flags and output register
  itp_datapath #(
    .StackDepth (StackDepth)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .symbol_i       (symbol_i),
    .end_of_input_i (end_of_input_i),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .out_symbol_o   (out_symbol_o),
    .end_marker_o   (end_marker_o),
    .overflow_o     (overflow_o),
    .last_o         (last_o),
    .cmd_i          (cmd),
    .sts_o          (sts)
  );

endmodule

// ----- sim/itp_postfix_checker.sv -----
// Result checker for the infix to postfix converter: watches both channels, predicts
// the postfix stream of each accepted request and compares it field by field.
// Depends on itp_pkg for the operator characters and codes.
module itp_postfix_checker #(
  parameter int unsigned Depth = itp_pkg::STACK_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  symbol_i,
  input  logic        end_of_input_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [7:0]  out_symbol_i,
  input  logic        end_marker_i,
  input  logic        overflow_i,
  input  logic        last_i,
  output int unsigned failures_o,
  output int unsigned outstanding_o
);
  import itp_pkg::*;

  typedef struct packed {
    logic [7:0] sym;
    logic       endm;
    logic       ovf;
    logic       lst;
  } postfix_result_t;

  // Shadow operator stack and sticky drop flag
  logic [OP_W-1:0] op_stack [Depth];
  int unsigned     stack_fill;
  logic            drop_seen;
  postfix_result_t postfix_q [$];
  int unsigned     fail_cnt = 0;

  function automatic int unsigned rank_of(input logic [OP_W-1:0] code);
    return (code == OP_MUL || code == OP_DIV) ? 2 : 1;
  endfunction

  function automatic logic [7:0] char_of(input logic [OP_W-1:0] code);
    case (code)
      OP_ADD:  return CHAR_ADD;
      OP_SUB:  return CHAR_SUB;
      OP_MUL:  return CHAR_MUL;
      default: return CHAR_DIV;
    endcase
  endfunction

  // Work out every result that one request causes and queue them in order
  task automatic predict_postfix(input logic [7:0] sym, input logic eoi);
    postfix_result_t batch [$];
    logic [OP_W-1:0] code;
    logic            is_op;
    is_op = 1'b1;
    code  = OP_ADD;
    case (sym)
      CHAR_ADD: code = OP_ADD;
      CHAR_SUB: code = OP_SUB;
      CHAR_MUL: code = OP_MUL;
      CHAR_DIV: code = OP_DIV;
      default:  is_op = 1'b0;
    endcase
    if (eoi) begin
      // flush the whole stack, then close with the marker
      while (stack_fill > 0) begin
        stack_fill--;
        batch.push_back('{sym: char_of(op_stack[stack_fill]), endm: 1'b0, ovf: 1'b0,
                          lst: 1'b0});
      end
      batch.push_back('{sym: 8'h00, endm: 1'b1, ovf: drop_seen, lst: 1'b0});
      drop_seen = 1'b0;
    end else if (!is_op) begin
      batch.push_back('{sym: sym, endm: 1'b0, ovf: 1'b0, lst: 1'b0});
    end else begin
      // pop every stacked operator of equal or higher precedence
      while (stack_fill > 0 && rank_of(op_stack[stack_fill-1]) >= rank_of(code)) begin
        stack_fill--;
        batch.push_back('{sym: char_of(op_stack[stack_fill]), endm: 1'b0, ovf: 1'b0,
                          lst: 1'b0});
      end
      if (stack_fill < Depth) begin
        op_stack[stack_fill] = code;
        stack_fill++;
      end else begin
        drop_seen = 1'b1;
      end
    end
    if (batch.size() > 0) batch[batch.size()-1].lst = 1'b1;
    foreach (batch[i]) postfix_q.push_back(batch[i]);
  endtask

  // Predict on each accepted request, compare on each accepted result
  always @(posedge clk_i or negedge rst_ni) begin
    postfix_result_t want;
    if (!rst_ni) begin
      stack_fill = 0;
      drop_seen  = 1'b0;
      postfix_q.delete();
    end else begin
      if (in_valid_i && !in_stall_i) predict_postfix(symbol_i, end_of_input_i);
      if (out_valid_i && !out_stall_i) begin
        if (postfix_q.size() == 0) begin
          $error("unexpected result: out_symbol %h end_marker %b", out_symbol_i,
                 end_marker_i);
          fail_cnt++;
        end else begin
          want = postfix_q.pop_front();
          if (out_symbol_i !== want.sym) begin
            $error("out_symbol: expected %h, actual %h", want.sym, out_symbol_i);
            fail_cnt++;
          end
          if (end_marker_i !== want.endm) begin
            $error("end_marker: expected %b, actual %b", want.endm, end_marker_i);
            fail_cnt++;
          end
          if (overflow_i !== want.ovf) begin
            $error("overflow: expected %b, actual %b", want.ovf, overflow_i);
            fail_cnt++;
          end
          if (last_i !== want.lst) begin
            $error("last: expected %b, actual %b", want.lst, last_i);
            fail_cnt++;
          end
        end
      end
    end
    failures_o    <= fail_cnt;
    outstanding_o <= postfix_q.size();
  end

endmodule

// ----- sim/tb_infix_to_postfix_converter.sv -----
// Testbench top for the infix to postfix converter: drives directed and random
// expressions with bursty requests and a stalling receiver, and gives the verdict.
// Depends on itp_pkg, infix_to_postfix_converter and itp_postfix_checker.
module tb_infix_to_postfix_converter;
  import itp_pkg::*;

  localparam int unsigned Depth      = STACK_DEPTH_DEF;
  localparam int unsigned RandomReqs = 205;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_TOGGLE
  } stall_mode_e;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        in_valid_i     = 1'b0;
  logic        in_stall_o;
  logic [7:0]  symbol_i       = 8'h00;
  logic        end_of_input_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i    = 1'b0;
  logic [7:0]  out_symbol_o;
  logic        end_marker_o;
  logic        overflow_o;
  logic        last_o;
  int unsigned failures;
  int unsigned outstanding;

  int unsigned burst_left = 0;
  int unsigned sent       = 0;
  stall_mode_e stall_mode = STALL_NONE;
  int unsigned stall_left = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  infix_to_postfix_converter #(
    .StackDepth(Depth)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .symbol_i      (symbol_i),
    .end_of_input_i(end_of_input_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_symbol_o  (out_symbol_o),
    .end_marker_o  (end_marker_o),
    .overflow_o    (overflow_o),
    .last_o        (last_o)
  );

  itp_postfix_checker #(
    .Depth(Depth)
  ) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .symbol_i      (symbol_i),
    .end_of_input_i(end_of_input_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_symbol_i  (out_symbol_o),
    .end_marker_i  (end_marker_o),
    .overflow_i    (overflow_o),
    .last_i        (last_o),
    .failures_o    (failures),
    .outstanding_o (outstanding)
  );

  // Receiver stall: switch between a few patterns every so often
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 3));
      stall_left = $urandom_range(8, 64);
    end
    stall_left--;
    case (stall_mode)
      STALL_NONE:  out_stall_i <= 1'b0;
      STALL_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall_i <= ($urandom_range(0, 3) != 0);
      default:     out_stall_i <= stall_left[1];
    endcase
  end

  // Send one request; open a gap when the current burst is used up
  task automatic send_request(input logic [7:0] sym, input logic eoi);
    int unsigned gap;
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      gap = $urandom_range(1, 8);
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                               : $urandom_range(1, 10);
    end
    in_valid_i     <= 1'b1;
    symbol_i       <= sym;
    end_of_input_i <= eoi;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    burst_left--;
    sent++;
  endtask

  // Hold the sender until every expected result has come
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  function automatic logic [7:0] rand_operator();
    case ($urandom_range(0, 3))
      0:       return CHAR_ADD;
      1:       return CHAR_SUB;
      2:       return CHAR_MUL;
      default: return CHAR_DIV;
    endcase
  endfunction

  function automatic logic [7:0] rand_operand();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == CHAR_ADD || b == CHAR_SUB || b == CHAR_MUL || b == CHAR_DIV);
    return b;
  endfunction

  task automatic close_expression();
    send_request(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // Well-formed expression: operand (operator operand)* then the end request
  task automatic send_expression();
    int unsigned terms;
    terms = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 14) : $urandom_range(1, 5);
    send_request(rand_operand(), 1'b0);
    repeat (terms - 1) begin
      send_request(rand_operator(), 1'b0);
      send_request(rand_operand(), 1'b0);
    end
    close_expression();
  endtask

  initial begin
    int unsigned kind;
    int unsigned n;
    bit          drained_mid;
    drained_mid = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: end on an empty stack
    send_request(8'hFF, 1'b1);
    // Extremes of the byte, every operator, pops on equal and higher precedence
    send_request(8'h00, 1'b0);
    send_request(CHAR_ADD, 1'b0);
    send_request(8'hFF, 1'b0);
    send_request(CHAR_MUL, 1'b0);
    send_request(8'h41, 1'b0);
    send_request(CHAR_SUB, 1'b0);
    send_request(8'h42, 1'b0);
    send_request(CHAR_DIV, 1'b0);
    send_request(8'h43, 1'b0);
    send_request(8'h00, 1'b1);
    // Operator with nothing to pop, then an equal-precedence pop
    send_request(CHAR_DIV, 1'b0);
    send_request(CHAR_DIV, 1'b0);
    close_expression();
    // Two stacked operators, a partial pop, then a two-deep flush
    send_request(CHAR_ADD, 1'b0);
    send_request(CHAR_MUL, 1'b0);
    send_request(CHAR_MUL, 1'b0);
    close_expression();
    drain_results();

    // Random: mostly well-formed expressions, some noise and broken ones
    while (sent < 18 + RandomReqs) begin
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        send_expression();
      end else if (kind < 9) begin
        n = $urandom_range(1, 6);
        repeat (n) send_request(8'($urandom_range(0, 255)), 1'b0);
        if ($urandom_range(0, 1) == 1) close_expression();
      end else begin
        send_request(rand_operator(), 1'b0);
        send_request(rand_operator(), 1'b0);
        send_request(rand_operand(), 1'b0);
        send_request(rand_operator(), 1'b0);
        close_expression();
      end
      if (!drained_mid && sent > 130) begin
        drain_results();
        drained_mid = 1'b1;
      end
    end
    close_expression();

    // Wait for the last results, then let any late extra result show up
    drain_results();
    repeat (50) @(posedge clk_i);
    if (failures == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #400000;
    $display("Mismatches found");
    $finish;
  end

endmodule
